@@ rtl/core/delta_zigzag_varint_decoder_macros.svh @@
// Assertion macros used by the checker file dzv_checker.sv.
`ifndef DELTA_ZIGZAG_VARINT_DECODER_MACROS_SVH
`define DELTA_ZIGZAG_VARINT_DECODER_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define DZV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dzv assertion failed");

// Check that a condition holds whenever the result channel shows a transfer candidate.
`define DZV_ASSERT_ON_VALID(label, clk, rst_n, vld, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) vld |-> (cond)) \
		else $error("dzv result check failed");

`endif

@@ rtl/core/dzv_pkg.sv @@
package dzv_pkg;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TRUNC    = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	localparam logic [2:0] SEED_BYTES      = 3'd4;
	localparam logic [2:0] LAST_GROUP_IDX  = 3'd4;
	localparam logic [23:0] LIMIT_RESET    = 24'hFFFFFF;

	typedef struct packed {
		logic [2:0]  seed_cnt;
		logic [31:0] prev_value;
		logic [31:0] group_acc;
		logic [2:0]  group_idx;
		logic [23:0] words;
		logic        discard;
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] value;
		logic [1:0]  status;
		logic        stream_end;
		logic [25:0] output_bytes;
	} result_t;

	localparam state_t STATE_CLEAR = '{
		seed_cnt: 3'd0, prev_value: 32'd0, group_acc: 32'd0,
		group_idx: 3'd0, words: 24'd0, discard: 1'b0
	};

endpackage

@@ rtl/core/dzv_step.sv @@
module dzv_step
	import dzv_pkg::*;
(
	input  state_t      cur,
	input  logic [23:0] word_limit,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output state_t      nxt,
	output result_t     res
);

	logic [31:0] seed_val;
	logic [31:0] acc_val;
	logic [31:0] sum_val;
	logic [31:0] word;
	logic [4:0]  grp_shift;
	logic        do_emit;
	logic        do_err;
	logic [1:0]  err_code;

	always_comb begin
		nxt       = cur;
		res       = '0;
		do_emit   = 1'b0;
		do_err    = 1'b0;
		err_code  = STATUS_OK;
		word      = 32'd0;
		seed_val  = cur.prev_value | ({24'd0, data_byte} << {cur.seed_cnt[1:0], 3'b000});
		grp_shift = 5'({2'b00, cur.group_idx} * 5'd7);
		acc_val   = cur.group_acc | ({25'd0, data_byte[6:0]} << grp_shift);
		sum_val   = cur.prev_value + ((acc_val >> 1) ^ {32{acc_val[0]}});

		if (cur.discard) begin
			if (last_byte) begin
				nxt = STATE_CLEAR;
			end
		end else if (cur.seed_cnt < SEED_BYTES) begin
			nxt.prev_value = seed_val;
			nxt.seed_cnt   = cur.seed_cnt + 3'd1;
			if (cur.seed_cnt == SEED_BYTES - 3'd1) begin
				do_emit = 1'b1;
				word    = seed_val;
			end else if (last_byte) begin
				do_err   = 1'b1;
				err_code = STATUS_TRUNC;
			end
		end else if (cur.group_idx > LAST_GROUP_IDX) begin
			do_err   = 1'b1;
			err_code = STATUS_RANGE;
		end else if (cur.group_idx == LAST_GROUP_IDX && data_byte[6:4] != 3'd0) begin
			do_err   = 1'b1;
			err_code = STATUS_RANGE;
		end else if (data_byte[7]) begin
			nxt.group_acc = acc_val;
			nxt.group_idx = cur.group_idx + 3'd1;
			if (last_byte) begin
				do_err   = 1'b1;
				err_code = STATUS_TRUNC;
			end
		end else begin
			nxt.group_acc = 32'd0;
			nxt.group_idx = 3'd0;
			do_emit       = 1'b1;
			word          = sum_val;
		end

		if (do_emit && cur.words >= word_limit) begin
			do_emit  = 1'b0;
			do_err   = 1'b1;
			err_code = STATUS_RANGE;
		end

		if (do_err) begin
			res.valid        = 1'b1;
			res.value        = 32'd0;
			res.status       = err_code;
			res.stream_end   = last_byte;
			res.output_bytes = {cur.words, 2'b00};
			if (last_byte) begin
				nxt = STATE_CLEAR;
			end else begin
				nxt.discard = 1'b1;
			end
		end else if (do_emit) begin
			res.valid        = 1'b1;
			res.value        = word;
			res.status       = STATUS_OK;
			res.stream_end   = last_byte;
			res.output_bytes = {cur.words + 24'd1, 2'b00};
			nxt.words        = cur.words + 24'd1;
			nxt.prev_value   = word;
			if (last_byte) begin
				nxt = STATE_CLEAR;
			end
		end
	end

endmodule

@@ rtl/core/delta_zigzag_varint_decoder.sv @@
// Delta / zigzag / LEB128 varint stream decoder.
// Input channel (s_*): one encoded byte per transfer, s_tlast marks the final
// byte of a stream. The first four bytes are a little-endian seed word; every
// later LEB128 group is unzigzagged and added to the previous word.
// Output channel (m_*): at most one result per input byte; m_tuser carries the
// status (ok, truncated, range error), m_tlast closes the stream.
// A result is registered and appears on m_* in the cycle after the byte that causes it.
// Throughput: one byte per cycle while s_tready is high; the decode step is one combinational pass
// between the stream state register and the output register.
// When the receiver stalls, the output register holds its result and s_tready
// drops only while that register is full and m_tready is low.
// Reset clears the stream state, empties the output register and sets
// output_word_limit (APB register 0, address 0) to its maximum.
// Write the limit only while no stream is in flight.
module delta_zigzag_varint_decoder
	import dzv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] value, [57:32] output_bytes, [63:58] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	state_t      state_q;
	state_t      state_nxt;
	result_t     res;
	logic [23:0] limit_q;
	logic        m_valid_q;
	logic [31:0] value_q;
	logic [25:0] obytes_q;
	logic [1:0]  status_q;
	logic        end_q;
	logic        s_xfer;

	dzv_step u_step (
		.cur        (state_q),
		.word_limit (limit_q),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.nxt        (state_nxt),
		.res        (res)
	);

	assign s_tready = !m_valid_q || m_tready;
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (s_xfer) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_xfer && res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && res.valid) begin
			value_q  <= res.value;
			obytes_q <= res.output_bytes;
			status_q <= res.status;
			end_q    <= res.stream_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			limit_q <= pwdata[23:0];
		end
	end

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {8'd0, limit_q};
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, obytes_q, value_q};
	assign m_tuser  = status_q;
	assign m_tlast  = end_q;

endmodule

@@ rtl/core/dzv_checker.sv @@
`include "delta_zigzag_varint_decoder_macros.svh"

module dzv_checker
	import dzv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	`DZV_ASSERT(a_hold_on_stall, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`DZV_ASSERT_ON_VALID(a_error_value_zero, clk, arst_n, m_tvalid, m_tuser == STATUS_OK || m_tdata[31:0] == 32'd0)
	`DZV_ASSERT_ON_VALID(a_trunc_ends_stream, clk, arst_n, m_tvalid, m_tuser != STATUS_TRUNC || m_tlast)
	`DZV_ASSERT_ON_VALID(a_bytes_whole_words, clk, arst_n, m_tvalid, m_tdata[33:32] == 2'b00)
	`DZV_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready)

endmodule

bind delta_zigzag_varint_decoder dzv_checker u_dzv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ test/tb_top.sv @@
module tb_top;
	import dzv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_WORD_LIMIT = 3'd0;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic        stream_end;
		logic [25:0] out_bytes;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] data_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;    // [31:0] value, [57:32] output_bytes, [63:58] zero
	logic [1:0]  m_tuser;    // [1:0] status
	logic        m_tlast;

	// decoder state mirror
	logic [23:0] word_limit;
	logic [2:0]  seed_cnt;
	logic [31:0] prev_word;
	logic [31:0] group_acc;
	logic [2:0]  group_idx;
	logic [23:0] word_cnt;
	logic        discard;

	decoded_t decoded_due[$];
	logic     quiet;
	int       fail_count;
	int       bytes_sent;
	int       streams_sent;
	int       words_seen;
	int       trunc_seen;
	int       range_seen;

	delta_zigzag_varint_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void clear_stream();
		seed_cnt = '0;
		prev_word = '0;
		group_acc = '0;
		group_idx = '0;
		word_cnt = '0;
		discard = 1'b0;
	endfunction

	function automatic void push_result(logic [31:0] val, logic [1:0] st, logic last);
		decoded_due.push_back('{value: val, status: st, stream_end: last,
			out_bytes: {word_cnt, 2'b00}});
	endfunction

	function automatic void flag_error(logic [1:0] st, logic last);
		push_result(32'd0, st, last);
		if (last)
			clear_stream();
		else
			discard = 1'b1;
	endfunction

	function automatic void emit_word(logic [31:0] word, logic last);
		if (word_cnt >= word_limit) begin
			flag_error(STATUS_RANGE, last);
			return;
		end
		word_cnt = word_cnt + 24'd1;
		prev_word = word;
		push_result(word, STATUS_OK, last);
		if (last)
			clear_stream();
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic last);
		logic [6:0]  payload;
		logic [31:0] delta;
		if (discard) begin
			if (last)
				clear_stream();
			return;
		end
		if (seed_cnt < SEED_BYTES) begin
			prev_word = prev_word | (32'(b) << (8 * seed_cnt));
			seed_cnt = seed_cnt + 3'd1;
			if (seed_cnt < SEED_BYTES) begin
				if (last)
					flag_error(STATUS_TRUNC, 1'b1);
				return;
			end
			emit_word(prev_word, last);
			return;
		end
		if (group_idx > LAST_GROUP_IDX) begin
			flag_error(STATUS_RANGE, last);
			return;
		end
		payload = b[6:0];
		if (group_idx == LAST_GROUP_IDX && payload > 7'h0f) begin
			flag_error(STATUS_RANGE, last);
			return;
		end
		group_acc = group_acc | (32'(payload) << (7 * group_idx));
		if (b[7]) begin
			group_idx = group_idx + 3'd1;
			if (last)
				flag_error(STATUS_TRUNC, 1'b1);
			return;
		end
		delta = (group_acc >> 1) ^ {32{group_acc[0]}};
		group_acc = '0;
		group_idx = '0;
		emit_word(prev_word + delta, last);
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		decoded_t got;
		decoded_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '{value: m_tdata[31:0], status: m_tuser, stream_end: m_tlast,
					out_bytes: m_tdata[57:32]};
				if (decoded_due.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					want = decoded_due.pop_front();
					compare_field("value", want.value, got.value);
					compare_field("status", 32'(want.status), 32'(got.status));
					compare_field("stream_end", 32'(want.stream_end), 32'(got.stream_end));
					compare_field("output_bytes", 32'(want.out_bytes), 32'(got.out_bytes));
					case (want.status)
						STATUS_OK: words_seen++;
						STATUS_TRUNC: trunc_seen++;
						default: range_seen++;
					endcase
				end
			end
		end
	end

	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(99) >= 7);

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (!quiet && $urandom_range(99) < 3) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
		if (last)
			streams_sent++;
	endtask

	task automatic send_seed(input logic [31:0] seed, input logic last);
		for (int i = 0; i < 4; i++)
			send_byte(seed[8*i +: 8], last && i == 3);
	endtask

	task automatic send_group(input logic [31:0] delta, input logic last);
		logic [31:0] z;
		logic        more;
		z = {delta[30:0], 1'b0} ^ {32{delta[31]}};
		do begin
			more = (z >> 7) != 0;
			send_byte({more, z[6:0]}, last && !more);
			z = z >> 7;
		end while (more);
	endtask

	task automatic send_noise(input int n, input logic close);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), close && i == n - 1);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (decoded_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_word_limit(input logic [23:0] lim);
		wait_for_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_WORD_LIMIT;
		pwdata <= {8'h00, lim};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		word_limit = lim;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {8'h00, lim}) begin
			$display("%0t ns: word limit readback mismatch, expected %h, actual %h",
				$time, {8'h00, lim}, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] random_delta();
		logic [31:0] pick;
		case ($urandom_range(4))
			0: pick = 32'($urandom_range(127)) - 32'd64;
			1: pick = $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
			2: pick = $urandom;
			3: begin
				case ($urandom_range(4))
					0: pick = 32'h0000_0000;
					1: pick = 32'h0000_0001;
					2: pick = 32'hFFFF_FFFF;
					3: pick = 32'h7FFF_FFFF;
					default: pick = 32'h8000_0000;
				endcase
			end
			default: pick = {{16{1'b1}}, 16'($urandom)};
		endcase
		return pick;
	endfunction

	// mostly well-formed streams, some cut short or overrun, some pure noise
	task automatic random_stream();
		int   kind;
		int   groups;
		int   n;
		logic close;
		kind = $urandom_range(99);
		groups = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
		if (kind < 5) begin
			send_noise($urandom_range(1, 3), 1'b1);
			return;
		end
		if (kind >= 90) begin
			send_noise($urandom_range(1, 14), 1'b1);
			return;
		end
		send_seed($urandom, groups == 0 && kind < 75);
		for (int i = 0; i < groups; i++)
			send_group(random_delta(), kind < 75 && i == groups - 1);
		if (kind < 75)
			return;
		close = 1'($urandom_range(1));
		case ($urandom_range(2))
			0: begin
				for (int i = 0; i < 4; i++)
					send_byte({1'b1, 7'($urandom)}, 1'b0);
				send_byte({1'($urandom), 7'($urandom_range(16, 127))}, close);
			end
			1: begin
				for (int i = 0; i < 4; i++)
					send_byte({1'b1, 7'($urandom)}, 1'b0);
				send_byte({4'b1000, 4'($urandom)}, 1'b0);
				send_byte(8'($urandom), close);
			end
			default: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n - 1; i++)
					send_byte({1'b1, 7'($urandom)}, 1'b0);
				if (n == 5)
					send_byte({4'b1000, 4'($urandom)}, 1'b1);
				else
					send_byte({1'b1, 7'($urandom)}, 1'b1);
				return;
			end
		endcase
		if (!close) begin
			send_noise($urandom_range(0, 3), 1'b0);
			send_byte(8'($urandom), 1'b1);
		end
	endtask

	task automatic run_streams(input int n);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n)
			random_stream();
	endtask

	task automatic test_seed_cases();
		send_byte(8'h5A, 1'b1);
		send_seed(32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_group_extremes();
		send_seed(32'h0000_0000, 1'b0);
		send_group(32'h8000_0000, 1'b0);
		send_group(32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_overrun_and_cutoff();
		send_seed(32'h1234_5678, 1'b0);
		for (int i = 0; i < 4; i++)
			send_byte(8'h80, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_seed(32'hA5C3_0F96, 1'b0);
		send_byte(8'h81, 1'b1);
	endtask

	task automatic test_word_limit();
		write_word_limit(24'd1);
		send_seed(32'hCAFE_F00D, 1'b0);
		send_group(32'd2, 1'b1);
	endtask

	task automatic test_random_full_limit();
		write_word_limit(LIMIT_RESET);
		quiet = 1'b1;
		run_streams(300);
		quiet = 1'b0;
		send_seed($urandom, 1'b0);
		wait_for_results();
		send_group(random_delta(), 1'b1);
		run_streams(500);
	endtask

	task automatic test_random_tight_limits();
		write_word_limit(24'd1);
		run_streams(150);
		write_word_limit(24'd2);
		run_streams(150);
		write_word_limit(24'($urandom_range(3, 8)));
		run_streams(150);
		write_word_limit(24'($urandom_range(3, 8)));
		run_streams(150);
	endtask

	task automatic test_random_wide_limits();
		write_word_limit(24'($urandom_range(1, 24'hFFFFFF)));
		run_streams(300);
		write_word_limit(LIMIT_RESET);
		run_streams(150);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		quiet = 1'b0;
		word_limit = LIMIT_RESET;
		clear_stream();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_seed_cases();
		test_group_extremes();
		test_overrun_and_cutoff();
		test_word_limit();
		test_random_full_limit();
		test_random_tight_limits();
		test_random_wide_limits();
		wait_for_results();

		$display("Sent %0d bytes in %0d streams; checked %0d words, %0d truncations, %0d range errors",
			bytes_sent, streams_sent, words_seen, trunc_seen, range_seen);
		$display("Word limits covered: 1, 2, small, random wide and the maximum");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still outstanding", decoded_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
